FILE: hdl/sca_pkg.sv
// ----------------------------------------------------------------------------
// Slab allocator package
// Sizes, state encoding and the request/response bundles that pass between
// the allocator sequencer and its list store.
// ----------------------------------------------------------------------------
package sca_pkg;

	// Heap geometry.
	localparam int CHUNK_BYTES = 4096;
	localparam int SIZE_STEP   = 16;
	localparam int CHUNK_LIMIT = 64;
	localparam int NUM_BINS    = 128;
	localparam int GRANULES    = CHUNK_LIMIT * CHUNK_BYTES / SIZE_STEP;

	// Field and internal widths.
	localparam int ADDR_W      = 18;
	localparam int SIZE_W      = 12;
	localparam int STEP_SHIFT  = 4;
	localparam int CHUNK_SHIFT = 12;
	localparam int GRAN_W      = 14;
	localparam int LINK_W      = GRAN_W + 1;
	localparam int BIN_W       = 7;
	localparam int CHUNK_W     = 6;
	localparam int CUSED_W     = CHUNK_W + 1;
	localparam int OFF_W       = CHUNK_SHIFT + 1;
	localparam int BINX_W      = SIZE_W - STEP_SHIFT;

	// Request function codes.
	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	// Sequencer states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_HEAD,
		ST_CARVE,
		ST_POP,
		ST_FTAG,
		ST_FHEAD
	} sca_state_t;

	// Store access bundle from the sequencer.
	typedef struct packed {
		logic               head_rd;
		logic [BIN_W-1:0]   head_rd_bin;
		logic               head_wr;
		logic [BIN_W-1:0]   head_wr_bin;
		logic [LINK_W-1:0]  head_wr_data;
		logic               link_rd;
		logic [GRAN_W-1:0]  link_rd_addr;
		logic               link_wr;
		logic [GRAN_W-1:0]  link_wr_addr;
		logic [LINK_W-1:0]  link_wr_data;
		logic               tag_rd;
		logic [CHUNK_W-1:0] tag_rd_chunk;
		logic               tag_wr;
		logic [CHUNK_W-1:0] tag_wr_chunk;
		logic [BIN_W-1:0]   tag_wr_data;
	} sca_mem_req_t;

	// Registered read data from the store.
	typedef struct packed {
		logic [LINK_W-1:0] head;
		logic [LINK_W-1:0] link;
		logic [BIN_W-1:0]  tag;
	} sca_mem_rsp_t;

endpackage

FILE: hdl/size_class_slab_allocator.sv
// ----------------------------------------------------------------------------
// Size class slab allocator
// Segregated free-list allocator over a heap of 64 chunks of 4096 bytes,
// with 128 size classes in steps of 16 bytes.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its result appears
// on slot_address and ok, marked by done for exactly one cycle, and cannot be
// held off by the receiver. An allocate from a non-empty bin and a free each
// pass through decode, memory read and read-modify-write of the list before
// busy drops, and done rises at the edge at which busy drops; a rejected
// request ends at decode, or at the bin head read when the heap is full. An
// allocate that finds its bin empty carves a fresh chunk, pushing its slots
// one at a time through the single offset adder and then fetching the link
// of the last slot pushed. A new request may be started in the cycle in
// which done is high.
// ----------------------------------------------------------------------------
module size_class_slab_allocator import sca_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic              func,
	input  logic [SIZE_W-1:0] alloc_size,
	input  logic [ADDR_W-1:0] free_address,
	output logic              done,
	output logic [ADDR_W-1:0] slot_address,
	output logic              ok
);

	sca_state_t state_q, state_d;

	logic               func_q;
	logic [SIZE_W-1:0]  size_q;
	logic [ADDR_W-1:0]  faddr_q;
	logic [BIN_W-1:0]   bin_q;
	logic [CUSED_W-1:0] chunks_used_q;
	logic [CHUNK_W-1:0] carve_chunk_q;
	logic [OFF_W-1:0]   off_q;
	logic [LINK_W-1:0]  cur_head_q;
	logic [ADDR_W-1:0]  addr_q;
	logic               done_q;
	logic [ADDR_W-1:0]  res_addr_q;
	logic               res_ok_q;

	sca_mem_req_t mem_req;
	sca_mem_rsp_t mem_rsp;

	logic [SIZE_W-1:0]  size_m1;
	logic [BINX_W-1:0]  bin_full;
	logic               size_bad;
	logic [CHUNK_W-1:0] free_chunk;
	logic               chunk_ok;
	logic               heap_full;
	logic [BIN_W:0]     bin_p1;
	logic [OFF_W-1:0]   slot_size;
	logic               carve_room;
	logic [GRAN_W-1:0]  carve_g;
	logic [LINK_W-1:0]  head_m1;
	logic [LINK_W-1:0]  cur_m1;
	logic               fin;
	logic               fin_ok;
	logic [ADDR_W-1:0]  fin_addr;

	sca_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mem_req),
		.rsp    (mem_rsp)
	);

	// Size class decode and range checks.
	assign size_m1    = size_q - SIZE_W'(1);
	assign bin_full   = size_m1[SIZE_W-1:STEP_SHIFT];
	assign size_bad   = (size_q == '0) || (bin_full >= BINX_W'(NUM_BINS));
	assign free_chunk = faddr_q[ADDR_W-1:CHUNK_SHIFT];
	assign chunk_ok   = {1'b0, free_chunk} < chunks_used_q;
	assign heap_full  = chunks_used_q == CUSED_W'(CHUNK_LIMIT);

	// Carve step: slot size, room check and granule of the current slot.
	assign bin_p1     = {1'b0, bin_q} + (BIN_W + 1)'(1);
	assign slot_size  = OFF_W'({bin_p1, {STEP_SHIFT{1'b0}}});
	assign carve_room = ({1'b0, off_q} + {1'b0, slot_size}) <= (OFF_W + 1)'(CHUNK_BYTES);
	assign carve_g    = {carve_chunk_q, off_q[CHUNK_SHIFT-1:STEP_SHIFT]};
	assign head_m1    = mem_rsp.head - LINK_W'(1);
	assign cur_m1     = cur_head_q - LINK_W'(1);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				if (func_q == FUNC_FREE) begin
					state_d = chunk_ok ? ST_FTAG : ST_IDLE;
				end else begin
					state_d = size_bad ? ST_IDLE : ST_HEAD;
				end
			end
			ST_HEAD: begin
				if (mem_rsp.head != '0) state_d = ST_POP;
				else if (heap_full) state_d = ST_IDLE;
				else state_d = ST_CARVE;
			end
			ST_CARVE: begin
				if (carve_room) state_d = ST_CARVE;
				else if (cur_head_q == '0) state_d = ST_IDLE;
				else state_d = ST_POP;
			end
			ST_POP:   state_d = ST_IDLE;
			ST_FTAG:  state_d = ST_FHEAD;
			ST_FHEAD: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Store accesses and completion per state.
	always_comb begin
		mem_req  = '0;
		fin      = 1'b0;
		fin_ok   = 1'b0;
		fin_addr = '0;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_DECODE: begin
				if (func_q == FUNC_FREE) begin
					mem_req.tag_rd       = chunk_ok;
					mem_req.tag_rd_chunk = free_chunk;
					fin                  = !chunk_ok;
				end else begin
					mem_req.head_rd     = !size_bad;
					mem_req.head_rd_bin = bin_full[BIN_W-1:0];
					fin                 = size_bad;
				end
			end
			ST_HEAD: begin
				if (mem_rsp.head != '0) begin
					mem_req.link_rd      = 1'b1;
					mem_req.link_rd_addr = head_m1[GRAN_W-1:0];
				end else if (heap_full) begin
					fin = 1'b1;
				end else begin
					mem_req.tag_wr       = 1'b1;
					mem_req.tag_wr_chunk = chunks_used_q[CHUNK_W-1:0];
					mem_req.tag_wr_data  = bin_q;
				end
			end
			ST_CARVE: begin
				if (carve_room) begin
					mem_req.link_wr      = 1'b1;
					mem_req.link_wr_addr = carve_g;
					mem_req.link_wr_data = cur_head_q;
				end else if (cur_head_q == '0) begin
					fin = 1'b1;
				end else begin
					mem_req.link_rd      = 1'b1;
					mem_req.link_rd_addr = cur_m1[GRAN_W-1:0];
				end
			end
			ST_POP: begin
				mem_req.head_wr      = 1'b1;
				mem_req.head_wr_bin  = bin_q;
				mem_req.head_wr_data = mem_rsp.link;
				fin                  = 1'b1;
				fin_ok               = 1'b1;
				fin_addr             = addr_q;
			end
			ST_FTAG: begin
				mem_req.head_rd     = 1'b1;
				mem_req.head_rd_bin = mem_rsp.tag;
			end
			ST_FHEAD: begin
				mem_req.link_wr      = 1'b1;
				mem_req.link_wr_addr = faddr_q[ADDR_W-1:STEP_SHIFT];
				mem_req.link_wr_data = mem_rsp.head;
				mem_req.head_wr      = 1'b1;
				mem_req.head_wr_bin  = bin_q;
				mem_req.head_wr_data = {1'b0, faddr_q[ADDR_W-1:STEP_SHIFT]} + LINK_W'(1);
				fin                  = 1'b1;
				fin_ok               = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			chunks_used_q <= '0;
			done_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (state_q == ST_HEAD && mem_rsp.head == '0 && !heap_full) begin
				chunks_used_q <= chunks_used_q + CUSED_W'(1);
			end
		end
	end

	// Request and working registers.
	always_ff @(posedge clk) begin
		if (fin) begin
			res_addr_q <= fin_addr;
			res_ok_q   <= fin_ok;
		end
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					func_q  <= func;
					size_q  <= alloc_size;
					faddr_q <= free_address;
				end
			end
			ST_DECODE: begin
				bin_q <= bin_full[BIN_W-1:0];
			end
			ST_HEAD: begin
				if (mem_rsp.head != '0) begin
					addr_q <= {head_m1[GRAN_W-1:0], {STEP_SHIFT{1'b0}}};
				end else begin
					carve_chunk_q <= chunks_used_q[CHUNK_W-1:0];
					off_q         <= slot_size;
					cur_head_q    <= '0;
				end
			end
			ST_CARVE: begin
				if (carve_room) begin
					cur_head_q <= {1'b0, carve_g} + LINK_W'(1);
					off_q      <= off_q + slot_size;
				end else begin
					addr_q <= {cur_m1[GRAN_W-1:0], {STEP_SHIFT{1'b0}}};
				end
			end
			ST_FTAG: begin
				bin_q <= mem_rsp.tag;
			end
			default: begin
			end
		endcase
	end

	assign busy         = state_q != ST_IDLE;
	assign done         = done_q;
	assign slot_address = res_addr_q;
	assign ok           = res_ok_q;

endmodule

FILE: hdl/sca_store.sv
// ----------------------------------------------------------------------------
// Slab allocator list store
// Holds the bin heads (with per-bin valid bits so reset empties every list),
// the per-granule next links and the per-chunk bin tags. All reads are
// registered; each memory has one write and one read address per cycle.
// ----------------------------------------------------------------------------
module sca_store import sca_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  sca_mem_req_t req,
	output sca_mem_rsp_t rsp
);

	logic [LINK_W-1:0] head_mem_q [NUM_BINS];
	logic [NUM_BINS-1:0] head_vld_q;
	logic [LINK_W-1:0] head_rd_q;
	logic              head_rd_vld_q;
	logic [LINK_W-1:0] link_mem_q [GRANULES];
	logic [LINK_W-1:0] link_rd_q;
	logic [BIN_W-1:0]  tag_mem_q [CHUNK_LIMIT];
	logic [BIN_W-1:0]  tag_rd_q;

	// Bin head valid bits: an invalid head reads as an empty list.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_vld_q    <= '0;
			head_rd_vld_q <= 1'b0;
		end else begin
			if (req.head_wr) begin
				head_vld_q[req.head_wr_bin] <= 1'b1;
			end
			if (req.head_rd) begin
				head_rd_vld_q <= head_vld_q[req.head_rd_bin];
			end
		end
	end

	// Bin head memory.
	always_ff @(posedge clk) begin
		if (req.head_wr) begin
			head_mem_q[req.head_wr_bin] <= req.head_wr_data;
		end
		if (req.head_rd) begin
			head_rd_q <= head_mem_q[req.head_rd_bin];
		end
	end

	// Next link memory, one entry per granule.
	always_ff @(posedge clk) begin
		if (req.link_wr) begin
			link_mem_q[req.link_wr_addr] <= req.link_wr_data;
		end
		if (req.link_rd) begin
			link_rd_q <= link_mem_q[req.link_rd_addr];
		end
	end

	// Chunk tag memory.
	always_ff @(posedge clk) begin
		if (req.tag_wr) begin
			tag_mem_q[req.tag_wr_chunk] <= req.tag_wr_data;
		end
		if (req.tag_rd) begin
			tag_rd_q <= tag_mem_q[req.tag_rd_chunk];
		end
	end

	assign rsp.head = head_rd_vld_q ? head_rd_q : '0;
	assign rsp.link = link_rd_q;
	assign rsp.tag  = tag_rd_q;

endmodule

FILE: verif/slab_grant_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slab allocator result checker
// Watches the request and result ports of the allocator, keeps its own copy
// of the bin lists, chunk tags and carve count, predicts the result of every
// accepted request and compares each result with the oldest prediction.
// ----------------------------------------------------------------------------
module slab_grant_checker import sca_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic              busy,
	input  logic              func,
	input  logic [SIZE_W-1:0] alloc_size,
	input  logic [ADDR_W-1:0] free_address,
	input  logic              done,
	input  logic [ADDR_W-1:0] slot_address,
	input  logic              ok,
	output int                error_count,
	output int                grants_pending
);

	typedef struct packed {
		logic [ADDR_W-1:0] slot_address;
		logic              ok;
	} grant_t;

	// Shadow allocator state. Heads and links hold granule + 1, zero is empty.
	logic [LINK_W-1:0] free_head [NUM_BINS];
	logic [LINK_W-1:0] free_next [GRANULES];
	logic [BIN_W-1:0]  chunk_bin [CHUNK_LIMIT];
	int                carved_chunks;

	// Results predicted for accepted requests, oldest first.
	grant_t            expected_grants [$];
	grant_t            want;

	// Push a slot onto the list of the bin that owns its chunk.
	function automatic logic return_slot(input logic [ADDR_W-1:0] addr);
		int chunk;
		int bin;
		int gran;
		chunk = addr >> CHUNK_SHIFT;
		if (chunk >= carved_chunks || chunk >= CHUNK_LIMIT)
			return 1'b0;
		bin  = chunk_bin[chunk];
		gran = addr >> STEP_SHIFT;
		if (bin >= NUM_BINS || gran >= GRANULES)
			return 1'b0;
		free_next[gran] = free_head[bin];
		free_head[bin]  = LINK_W'(gran + 1);
		return 1'b1;
	endfunction

	// Tag the next chunk with the bin and push its whole slots in ascending order.
	function automatic void carve_chunk(input int bin);
		int slot_bytes;
		int base;
		slot_bytes = (bin + 1) * SIZE_STEP;
		if (carved_chunks >= CHUNK_LIMIT)
			return;
		base = carved_chunks * CHUNK_BYTES;
		chunk_bin[carved_chunks] = BIN_W'(bin);
		carved_chunks++;
		for (int p = base + slot_bytes; p + slot_bytes <= base + CHUNK_BYTES; p += slot_bytes)
			void'(return_slot(ADDR_W'(p)));
	endfunction

	// Pop the head of the size class, carving a chunk when the list is empty.
	function automatic grant_t take_slot(input logic [SIZE_W-1:0] size);
		grant_t grant;
		int     bin;
		int     head;
		grant = '0;
		if (size == '0)
			return grant;
		bin = (int'(size) - 1) / SIZE_STEP;
		if (bin >= NUM_BINS)
			return grant;
		if (free_head[bin] == '0)
			carve_chunk(bin);
		head = free_head[bin];
		if (head != 0 && head - 1 < GRANULES) begin
			grant.slot_address = ADDR_W'((head - 1) * SIZE_STEP);
			grant.ok           = 1'b1;
			free_head[bin]     = free_next[head - 1];
		end
		return grant;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BINS; i++)
				free_head[i] = '0;
			carved_chunks = 0;
			expected_grants.delete();
			error_count    = 0;
			grants_pending = 0;
		end else begin
			// A finished request is compared with the oldest prediction.
			if (done) begin
				if (expected_grants.size() == 0) begin
					$error("result with no request outstanding: slot_address %0h ok %0b",
						slot_address, ok);
					error_count++;
				end else begin
					want = expected_grants.pop_front();
					if (slot_address !== want.slot_address) begin
						$error("slot_address: expected %0h, actual %0h",
							want.slot_address, slot_address);
						error_count++;
					end
					if (ok !== want.ok) begin
						$error("ok: expected %0b, actual %0b", want.ok, ok);
						error_count++;
					end
				end
			end

			// Every accepted request gets its result predicted right away.
			if (start && !busy) begin
				if (func == FUNC_FREE) begin
					want    = '0;
					want.ok = return_slot(free_address);
				end else begin
					want = take_slot(alloc_size);
				end
				expected_grants.push_back(want);
			end
			grants_pending = expected_grants.size();
		end
	end

endmodule

FILE: verif/size_class_slab_allocator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Slab allocator testbench
// Drives allocate and free requests into the allocator: a directed opening
// over bad sizes, carving, reuse, misaligned, double and stray frees, then
// random traffic that mostly allocates and often frees slots it was granted earlier. A checker
// beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module size_class_slab_allocator_test;
	import sca_pkg::*;

	localparam int RANDOM_REQUESTS = 1630;

	logic              clk          = 1'b0;
	logic              arst_n       = 1'b0;
	logic              start        = 1'b0;
	logic              func         = FUNC_ALLOC;
	logic [SIZE_W-1:0] alloc_size   = '0;
	logic [ADDR_W-1:0] free_address = '0;
	logic              busy;
	logic              done;
	logic [ADDR_W-1:0] slot_address;
	logic              ok;
	int                error_count;
	int                grants_pending;

	// Slots granted so far and not yet taken out for a free.
	logic [ADDR_W-1:0] live_slots [$];

	// Size classes that carry most of the random allocations.
	int                hot_bins [7] = '{0, 1, 2, 5, 12, 40, 127};

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	size_class_slab_allocator dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.func         (func),
		.alloc_size   (alloc_size),
		.free_address (free_address),
		.done         (done),
		.slot_address (slot_address),
		.ok           (ok)
	);

	slab_grant_checker grant_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.func           (func),
		.alloc_size     (alloc_size),
		.free_address   (free_address),
		.done           (done),
		.slot_address   (slot_address),
		.ok             (ok),
		.error_count    (error_count),
		.grants_pending (grants_pending)
	);

	// Granted slots are picked up mid-cycle, away from the clock edge.
	always @(negedge clk) begin
		if (arst_n && done && ok && slot_address != '0)
			live_slots.push_back(slot_address);
	end

	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	// Present one request and hold it until the block takes it.
	task automatic send_request(input logic f, input logic [SIZE_W-1:0] sz,
			input logic [ADDR_W-1:0] fa);
		start        <= 1'b1;
		func         <= f;
		alloc_size   <= sz;
		free_address <= fa;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic send_alloc(input logic [SIZE_W-1:0] sz);
		send_request(FUNC_ALLOC, sz, ADDR_W'($urandom_range(2**ADDR_W - 1)));
	endtask

	task automatic send_free(input logic [ADDR_W-1:0] fa);
		send_request(FUNC_FREE, SIZE_W'($urandom_range(2**SIZE_W - 1)), fa);
	endtask

	task automatic hold_off(input int cycles);
		start <= 1'b0;
		repeat (cycles)
			@(posedge clk);
	endtask

	// Stop issuing until every outstanding request has returned its result.
	// The count is first read mid-cycle, once the last request is counted.
	task automatic drain();
		start <= 1'b0;
		do
			@(negedge clk);
		while (grants_pending != 0);
		@(posedge clk);
	endtask

	initial begin : stimulus
		int                roll;
		int                pick;
		logic [ADDR_W-1:0] addr;

		repeat (6)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Stray frees before anything is carved, then bad sizes.
		send_free('0);
		send_free('1);
		send_alloc('0);
		send_alloc('1);
		send_alloc(SIZE_W'(NUM_BINS * SIZE_STEP + 1));

		// Smallest class carves chunk 0, next class carves chunk 1.
		send_alloc(1);
		send_alloc(16);
		send_alloc(17);
		send_free(18'h00FF0);
		send_alloc(5);
		// Misaligned free drops the low bits.
		send_free(18'h00FE7);
		// Chunk 2 is not carved yet.
		send_free(18'h02000);

		// Largest class holds one slot per chunk.
		send_alloc(SIZE_W'(NUM_BINS * SIZE_STEP));
		send_alloc(2033);
		// A tag slot is trusted like any other slot.
		send_free(18'h02000);
		send_alloc(2047);

		// Double free in a class outside the hot classes of the random traffic.
		send_alloc(64);
		send_free(18'h04FC0);
		send_free(18'h04FC0);
		send_alloc(49);
		send_alloc(64);
		send_free(18'h3FFF0);

		drain();

		// Random traffic: mostly hot classes and returns of granted slots.
		for (int n = 0; n < RANDOM_REQUESTS; n++) begin
			if (n == RANDOM_REQUESTS / 2)
				drain();
			roll = $urandom_range(99);
			if (roll < 40 || (roll >= 55 && roll < 90 && live_slots.size() == 0)) begin
				send_alloc(SIZE_W'(hot_bins[$urandom_range(6)] * SIZE_STEP
					+ $urandom_range(1, SIZE_STEP)));
			end else if (roll < 55) begin
				send_alloc(SIZE_W'($urandom_range(1, NUM_BINS * SIZE_STEP)));
			end else if (roll < 88) begin
				pick = $urandom_range(live_slots.size() - 1);
				addr = live_slots[pick];
				live_slots.delete(pick);
				if ($urandom_range(3) == 0)
					addr = addr | ADDR_W'($urandom_range(1, SIZE_STEP - 1));
				send_free(addr);
			end else if (roll < 90) begin
				send_free(live_slots[$urandom_range(live_slots.size() - 1)]);
			end else if (roll < 95) begin
				send_free(ADDR_W'($urandom_range(2**ADDR_W - 1)));
			end else begin
				send_alloc(SIZE_W'($urandom_range(2**SIZE_W - 1)));
			end

			// Sender gaps, except over one long back-to-back stretch.
			if ((n < 600 || n > 900) && $urandom_range(99) < 8)
				hold_off($urandom_range(1, 6));
		end

		drain();
		repeat (20)
			@(posedge clk);

		if (error_count == 0 && grants_pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

FILE: size_class_slab_allocator.f
hdl/sca_pkg.sv
hdl/sca_store.sv
hdl/size_class_slab_allocator.sv
verif/slab_grant_checker.sv
verif/size_class_slab_allocator_test.sv
